// ===== hw/rtl/srlb_pkg.sv =====
// ----------------------------------------------------------------------------
// srlb_pkg
// Types and constants shared by the sonar range and LED blinker block.
// ----------------------------------------------------------------------------
package srlb_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_CM     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_HALF_TICKS = 3'd4;

   // Register widths.
   localparam int TRIGGER_W = 10;
   localparam int SETTLE_W  = 20;
   localparam int PER_CM_W  = 8;
   localparam int LIMIT_W   = 10;
   localparam int BLINK_W   = 24;

   // Counter widths.
   localparam int PHASE_CNT_W = 20;

   // Register reset values.
   localparam logic [TRIGGER_W-1:0] TRIGGER_TICKS_RST    = 10'd20;
   localparam logic [SETTLE_W-1:0]  SETTLE_TICKS_RST     = 20'd30000;
   localparam logic [PER_CM_W-1:0]  TICKS_PER_CM_RST     = 8'd58;
   localparam logic [LIMIT_W-1:0]   DISTANCE_LIMIT_RST   = 10'd12;
   localparam logic [BLINK_W-1:0]   BLINK_HALF_TICKS_RST = 24'd500000;

   typedef enum logic [1:0] {
      PH_SETTLE  = 2'd0,
      PH_TRIGGER = 2'd1,
      PH_WAIT    = 2'd2,
      PH_MEASURE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TRIGGER_W-1:0] trigger_ticks;
      logic [SETTLE_W-1:0]  settle_ticks;
      logic [PER_CM_W-1:0]  ticks_per_cm;
      logic [LIMIT_W-1:0]   distance_limit;
      logic [BLINK_W-1:0]   blink_half_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type              phase;
      logic [PHASE_CNT_W-1:0] phase_count;
      logic                   blink_active;
      logic                   led_on;
   } status_type;

endpackage

// ===== hw/rtl/srlb_csr.sv =====
// ----------------------------------------------------------------------------
// srlb_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module srlb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [srlb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srlb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output srlb_pkg::cfg_type                   cfg
);

   srlb_pkg::cfg_type cfg_ff;
   srlb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            srlb_pkg::CSR_TRIGGER_TICKS: begin
               cfg_in.trigger_ticks = csr_wdata[srlb_pkg::TRIGGER_W-1:0];
            end
            srlb_pkg::CSR_SETTLE_TICKS: begin
               cfg_in.settle_ticks = csr_wdata[srlb_pkg::SETTLE_W-1:0];
            end
            srlb_pkg::CSR_TICKS_PER_CM: begin
               cfg_in.ticks_per_cm = csr_wdata[srlb_pkg::PER_CM_W-1:0];
            end
            srlb_pkg::CSR_DISTANCE_LIMIT: begin
               cfg_in.distance_limit = csr_wdata[srlb_pkg::LIMIT_W-1:0];
            end
            srlb_pkg::CSR_BLINK_HALF_TICKS: begin
               cfg_in.blink_half_ticks = csr_wdata[srlb_pkg::BLINK_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks    <= srlb_pkg::TRIGGER_TICKS_RST;
         cfg_ff.settle_ticks     <= srlb_pkg::SETTLE_TICKS_RST;
         cfg_ff.ticks_per_cm     <= srlb_pkg::TICKS_PER_CM_RST;
         cfg_ff.distance_limit   <= srlb_pkg::DISTANCE_LIMIT_RST;
         cfg_ff.blink_half_ticks <= srlb_pkg::BLINK_HALF_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/srlb_core.sv =====
// ----------------------------------------------------------------------------
// srlb_core
// Per-tick sequencer: settle, trigger, echo wait and measurement, plus the
// LED blink timer. State advances once for every tick that moves forward.
// ----------------------------------------------------------------------------
module srlb_core #(
   parameter int DISTANCE_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      echo_level,
   input  srlb_pkg::cfg_type         cfg,
   output logic                      trigger_level,
   output logic                      led_level,
   output logic                      distance_valid,
   output logic [DISTANCE_BITS-1:0]  distance_cm,
   output srlb_pkg::status_type      status
);

   localparam int CNT_W = srlb_pkg::PHASE_CNT_W;
   localparam int CMP_W = (DISTANCE_BITS > srlb_pkg::LIMIT_W) ? DISTANCE_BITS
                                                              : srlb_pkg::LIMIT_W;
   localparam logic [CNT_W-1:0] DIST_MAX = CNT_W'((64'd1 << DISTANCE_BITS) - 64'd1);

   srlb_pkg::phase_type                   phase_ff, phase_in;
   logic [CNT_W-1:0]                      phase_count_ff, phase_count_in;
   logic [srlb_pkg::PER_CM_W-1:0]         sub_cm_ff, sub_cm_in;
   logic [DISTANCE_BITS-1:0]              last_dist_ff, last_dist_in;
   logic                                  blink_active_ff, blink_active_in;
   logic                                  led_on_ff, led_on_in;
   logic [srlb_pkg::BLINK_W-1:0]          blink_count_ff, blink_count_in;

   logic [CNT_W-1:0]                      count_inc;
   logic                                  settle_done;
   logic                                  trigger_done;
   logic [srlb_pkg::PER_CM_W-1:0]         sub_base;
   logic [srlb_pkg::PER_CM_W-1:0]         sub_tick;
   logic                                  cm_step;
   logic [CNT_W-1:0]                      cm_base;
   logic [CNT_W-1:0]                      cm_next;
   logic [srlb_pkg::BLINK_W-1:0]          blink_inc;
   logic                                  blink_wrap;
   logic                                  done;
   logic                                  over_limit;

   // A timing register of zero behaves as one, so the compare turns into a
   // test for a non-zero count.
   assign count_inc    = phase_count_ff + CNT_W'(1);
   assign settle_done  = (cfg.settle_ticks == '0) ? (count_inc != '0)
                                                  : (count_inc >= cfg.settle_ticks);
   assign trigger_done = (cfg.trigger_ticks == '0) ? (count_inc != '0)
                         : (count_inc >= CNT_W'(cfg.trigger_ticks));

   // The rising echo tick already counts as the first high tick.
   assign sub_base = (phase_ff == srlb_pkg::PH_WAIT) ? '0 : sub_cm_ff;
   assign cm_base  = (phase_ff == srlb_pkg::PH_WAIT) ? '0 : phase_count_ff;
   assign sub_tick = sub_base + srlb_pkg::PER_CM_W'(1);
   assign cm_step  = (cfg.ticks_per_cm == '0) ? (sub_tick != '0)
                                              : (sub_tick >= cfg.ticks_per_cm);
   assign cm_next  = (cm_step && (cm_base < DIST_MAX)) ? cm_base + CNT_W'(1) : cm_base;

   assign blink_inc  = blink_count_ff + srlb_pkg::BLINK_W'(1);
   assign blink_wrap = (cfg.blink_half_ticks == '0) ? (blink_inc != '0)
                                                    : (blink_inc >= cfg.blink_half_ticks);

   assign done       = (phase_ff == srlb_pkg::PH_MEASURE) && !echo_level;
   assign over_limit = CMP_W'(phase_count_ff[DISTANCE_BITS-1:0])
                       > CMP_W'(cfg.distance_limit);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         srlb_pkg::PH_SETTLE: begin
            if (settle_done) begin
               phase_in = srlb_pkg::PH_TRIGGER;
            end
         end
         srlb_pkg::PH_TRIGGER: begin
            if (trigger_done) begin
               phase_in = srlb_pkg::PH_WAIT;
            end
         end
         srlb_pkg::PH_WAIT: begin
            if (echo_level) begin
               phase_in = srlb_pkg::PH_MEASURE;
            end
         end
         srlb_pkg::PH_MEASURE: begin
            if (!echo_level) begin
               phase_in = srlb_pkg::PH_SETTLE;
            end
         end
         default: begin
            phase_in = srlb_pkg::PH_SETTLE;
         end
      endcase
   end

   // Counters, distance and outputs.
   always_comb begin
      phase_count_in = phase_count_ff;
      sub_cm_in      = sub_cm_ff;
      last_dist_in   = last_dist_ff;
      trigger_level  = 1'b0;
      case (phase_ff)
         srlb_pkg::PH_SETTLE: begin
            phase_count_in = settle_done ? '0 : count_inc;
         end
         srlb_pkg::PH_TRIGGER: begin
            trigger_level  = 1'b1;
            phase_count_in = trigger_done ? '0 : count_inc;
         end
         srlb_pkg::PH_WAIT: begin
            if (echo_level) begin
               phase_count_in = cm_next;
               sub_cm_in      = cm_step ? '0 : sub_tick;
            end
         end
         srlb_pkg::PH_MEASURE: begin
            if (echo_level) begin
               phase_count_in = cm_next;
               sub_cm_in      = cm_step ? '0 : sub_tick;
            end else begin
               last_dist_in   = phase_count_ff[DISTANCE_BITS-1:0];
               phase_count_in = '0;
               sub_cm_in      = '0;
            end
         end
         default: begin
            phase_count_in = '0;
         end
      endcase

      blink_active_in = blink_active_ff;
      led_on_in       = led_on_ff;
      blink_count_in  = blink_count_ff;
      if (blink_active_ff) begin
         blink_count_in = blink_wrap ? '0 : blink_inc;
         led_on_in      = led_on_ff ^ blink_wrap;
      end
      // The distance decision comes after the blink timer on a finishing tick.
      if (done) begin
         if (over_limit) begin
            led_on_in       = 1'b0;
            blink_active_in = 1'b0;
            blink_count_in  = '0;
         end else if (!blink_active_ff) begin
            led_on_in       = 1'b1;
            blink_active_in = 1'b1;
            blink_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= srlb_pkg::PH_SETTLE;
         phase_count_ff  <= '0;
         sub_cm_ff       <= '0;
         last_dist_ff    <= '0;
         blink_active_ff <= 1'b0;
         led_on_ff       <= 1'b0;
         blink_count_ff  <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         phase_count_ff  <= phase_count_in;
         sub_cm_ff       <= sub_cm_in;
         last_dist_ff    <= last_dist_in;
         blink_active_ff <= blink_active_in;
         led_on_ff       <= led_on_in;
         blink_count_ff  <= blink_count_in;
      end
   end

   assign led_level      = led_on_in;
   assign distance_valid = done;
   assign distance_cm    = last_dist_in;

   assign status.phase        = phase_ff;
   assign status.phase_count  = phase_count_ff;
   assign status.blink_active = blink_active_ff;
   assign status.led_on       = led_on_ff;

endmodule

// ===== hw/rtl/sonar_range_led_blinker_core.sv =====
// ----------------------------------------------------------------------------
// sonar_range_led_blinker_core
// Ultrasonic rangefinder sequencer with a distance-gated blinking LED.
// ----------------------------------------------------------------------------
// Each transfer on req_ is one microsecond tick carrying the sampled echo
// level, and it yields exactly one transfer on rsp_ with the trigger drive,
// the LED drive, a distance-finished flag and the last distance in whole
// centimeters. A tick passes through an input register and a result register,
// with the sequencer and blink timer updating in between, so one tick is taken
// every clock cycle while rsp_tready keeps the result register draining, and
// its result is offered on rsp_ from the result register. While rsp_tready
// stays low the block holds two ticks and then lowers req_tready.
// The user must write configuration registers through csr_ only while no tick
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sonar_range_led_blinker_core #(
   parameter int DISTANCE_BITS = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Tick stream.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [7:0]                               req_tdata,  // echo_level
   // Result stream.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // trigger_level, led_level, distance_valid, distance_cm
   output logic [((DISTANCE_BITS + 3 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Configuration write port.
   input  logic                                     csr_we,
   input  logic [srlb_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [srlb_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int RSP_W = ((DISTANCE_BITS + 3 + 7) / 8) * 8;
   localparam logic [srlb_pkg::PHASE_CNT_W-1:0] DIST_MAX =
      srlb_pkg::PHASE_CNT_W'((64'd1 << DISTANCE_BITS) - 64'd1);

   srlb_pkg::cfg_type    cfg;
   srlb_pkg::status_type status;

   logic                      in_valid_ff, in_valid_in;
   logic                      echo_ff;
   logic                      advance;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff;
   logic                      trigger_level;
   logic                      led_level;
   logic                      distance_valid;
   logic [DISTANCE_BITS-1:0]  distance_cm;

   srlb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srlb_core #(
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .echo_level     (echo_ff),
      .cfg            (cfg),
      .trigger_level  (trigger_level),
      .led_level      (led_level),
      .distance_valid (distance_valid),
      .distance_cm    (distance_cm),
      .status         (status)
   );

   // A tick moves into the result register whenever that register is empty
   // or is being drained in the same cycle.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         echo_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_data_ff <= RSP_W'({distance_cm, distance_valid, led_level, trigger_level});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The trigger is never driven on the tick that finishes a distance.
   a_trig_excl_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[2]))
      else $error("trigger and distance_valid set in the same result");

   // The LED is only lit while blinking is active.
   a_led_needs_blink: assert property (@(posedge clock) disable iff (reset)
      status.led_on |-> status.blink_active)
      else $error("LED on while blinking is inactive");

   // A finished distance always sends the sequencer back to settling.
   a_done_to_settle: assert property (@(posedge clock) disable iff (reset)
      (advance && distance_valid) |=> (status.phase == srlb_pkg::PH_SETTLE))
      else $error("sequencer did not return to settle after a distance");

   // The running centimeter count stays within the saturation limit.
   a_cm_saturates: assert property (@(posedge clock) disable iff (reset)
      (status.phase == srlb_pkg::PH_MEASURE) |-> (status.phase_count <= DIST_MAX))
      else $error("centimeter count beyond the saturation limit");

endmodule
